/* hw/rtl/rgb_current_grid_smoother_assert.svh */
// Assertion macros shared by the checker files of the grid smoother.
// Depends on signals named clock and reset in the module that uses them.
`ifndef RGB_CURRENT_GRID_SMOOTHER_ASSERT_SVH
`define RGB_CURRENT_GRID_SMOOTHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RCGS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RCGS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/rcgs_pkg.sv */
// Package for the RGB current grid smoother: sizes, codes and shared types.
// Used by the controller, the datapath, the top level and the checker.
package rcgs_pkg;

   localparam int GRID_LEVELS  = 10;
   localparam int SAMPLE_BITS  = 16;
   localparam int LEVEL_BITS   = 4;
   localparam int OUT_BITS     = 20;
   localparam int FRAC_BITS    = 4;
   localparam int SUM_DIVISOR  = 9;
   localparam int ROUND_BIAS   = 4;

   localparam int CELL_COUNT   = GRID_LEVELS * GRID_LEVELS * GRID_LEVELS;
   localparam int ADDR_BITS    = $clog2(CELL_COUNT);
   localparam int STRIDE_RED   = GRID_LEVELS * GRID_LEVELS;
   localparam int STRIDE_GREEN = GRID_LEVELS;
   localparam int STRIDE_BLUE  = 1;

   // Nine samples at most, so four extra bits hold the sum.
   localparam int SUM_BITS     = SAMPLE_BITS + 4;
   localparam int NUM_BITS     = SUM_BITS + FRAC_BITS;

   // Reciprocal of nine, rounded up. With four guard bits over the numerator
   // width the truncated product equals the exact floor of the quotient.
   localparam int RECIP_SHIFT  = NUM_BITS + 4;
   localparam int RECIP_BITS   = RECIP_SHIFT - 3;
   localparam longint unsigned RECIP_VALUE =
      ((64'd1 << RECIP_SHIFT) + 64'(SUM_DIVISOR - 1)) / 64'(SUM_DIVISOR);
   localparam int PROD_BITS    = NUM_BITS + RECIP_BITS;
   localparam int QUO_BITS     = PROD_BITS - RECIP_SHIFT;
   localparam longint unsigned OUT_MAX = (64'd1 << OUT_BITS) - 64'd1;

   typedef logic [LEVEL_BITS-1:0]  level_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [OUT_BITS-1:0]    out_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } rcgs_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_FETCH,
      ST_DRAIN,
      ST_DIVIDE,
      ST_FINISH
   } rcgs_state_type;

   // Order of the seven memory reads of one smoothed cell.
   typedef enum logic [2:0] {
      STEP_CENTRE,
      STEP_RED_LO,
      STEP_RED_HI,
      STEP_GREEN_LO,
      STEP_GREEN_HI,
      STEP_BLUE_LO,
      STEP_BLUE_HI
   } rcgs_step_type;

   typedef struct packed {
      logic          capture;
      logic          write;
      logic          read;
      rcgs_step_type step;
      logic          divide;
      logic          load_out;
   } rcgs_cmd_type;

   typedef struct packed {
      logic req_is_read;
      logic out_free;
   } rcgs_status_type;

   // Levels past the grid clamp to the last level.
   function automatic level_type sat_level(input level_type lvl);
      if ({1'b0, lvl} >= (LEVEL_BITS + 1)'(GRID_LEVELS)) begin
         return LEVEL_BITS'(GRID_LEVELS - 1);
      end
      return lvl;
   endfunction

   function automatic logic is_edge(input level_type lvl);
      return (lvl == '0) || (lvl == LEVEL_BITS'(GRID_LEVELS - 1));
   endfunction

endpackage

/* hw/rtl/rcgs_ctrl.sv */
// Controller of the grid smoother: sequences writes and the seven-read fetch.
// Depends on rcgs_pkg for the state, step, command and status types.
module rcgs_ctrl
   import rcgs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  rcgs_status_type status,
   output rcgs_cmd_type    cmd
);

   rcgs_state_type state_ff, state_in;
   rcgs_step_type  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_CENTRE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      cmd.step  = step_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            step_in   = STEP_CENTRE;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.req_is_read ? ST_FETCH : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_FETCH: begin
            cmd.read = 1'b1;
            if (step_ff == STEP_BLUE_HI) begin
               step_in  = STEP_CENTRE;
               state_in = ST_DRAIN;
            end else begin
               step_in = rcgs_step_type'(step_ff + 3'd1);
            end
         end
         // The last read lands in the accumulator during this cycle.
         ST_DRAIN: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/rcgs_datapath.sv */
// Datapath of the grid smoother: cell memory, neighbor addressing,
// accumulator, divide by nine and the result register. Depends on rcgs_pkg.
module rcgs_datapath
   import rcgs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_opcode,
   input  level_type       req_red_level,
   input  level_type       req_green_level,
   input  level_type       req_blue_level,
   input  sample_type      req_sample,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output out_type         rsp_filtered_value,
   input  rcgs_cmd_type    cmd,
   output rcgs_status_type status
);

   sample_type cell_mem [CELL_COUNT];

   level_type  red_sat, green_sat, blue_sat;
   addr_type   centre_in;
   addr_type   centre_ff;
   logic [2:0] edge_ff;
   sample_type sample_ff;
   addr_type   mem_addr;
   sample_type rdata_ff;
   logic       rvalid_ff;
   logic       rcentre_ff;
   logic [SUM_BITS-1:0]  acc_ff, acc_in, addend;
   logic [NUM_BITS-1:0]  numer;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [QUO_BITS-1:0]  quot;
   out_type    result;
   out_type    out_ff;
   logic       out_valid_ff;

   assign red_sat   = sat_level(req_red_level);
   assign green_sat = sat_level(req_green_level);
   assign blue_sat  = sat_level(req_blue_level);
   assign centre_in = ADDR_BITS'(red_sat) * ADDR_BITS'(STRIDE_RED)
                    + ADDR_BITS'(green_sat) * ADDR_BITS'(STRIDE_GREEN)
                    + ADDR_BITS'(blue_sat);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         centre_ff <= centre_in;
         edge_ff   <= {is_edge(red_sat), is_edge(green_sat), is_edge(blue_sat)};
         sample_ff <= req_sample;
      end
   end

   // On an edge axis both neighbors fall back to the center, which then
   // counts three times for that axis.
   always_comb begin
      unique case (cmd.step)
         STEP_CENTRE:   mem_addr = centre_ff;
         STEP_RED_LO:   mem_addr = edge_ff[2] ? centre_ff
                                              : centre_ff - ADDR_BITS'(STRIDE_RED);
         STEP_RED_HI:   mem_addr = edge_ff[2] ? centre_ff
                                              : centre_ff + ADDR_BITS'(STRIDE_RED);
         STEP_GREEN_LO: mem_addr = edge_ff[1] ? centre_ff
                                              : centre_ff - ADDR_BITS'(STRIDE_GREEN);
         STEP_GREEN_HI: mem_addr = edge_ff[1] ? centre_ff
                                              : centre_ff + ADDR_BITS'(STRIDE_GREEN);
         STEP_BLUE_LO:  mem_addr = edge_ff[0] ? centre_ff
                                              : centre_ff - ADDR_BITS'(STRIDE_BLUE);
         STEP_BLUE_HI:  mem_addr = edge_ff[0] ? centre_ff
                                              : centre_ff + ADDR_BITS'(STRIDE_BLUE);
         default:       mem_addr = centre_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         cell_mem[mem_addr] <= sample_ff;
      end
      rdata_ff <= cell_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff  <= 1'b0;
         rcentre_ff <= 1'b0;
      end else begin
         rvalid_ff  <= cmd.read;
         rcentre_ff <= cmd.read && (cmd.step == STEP_CENTRE);
      end
   end

   // The center appears once in each of the three axis terms.
   assign addend = rcentre_ff ? SUM_BITS'(rdata_ff) + (SUM_BITS'(rdata_ff) << 1)
                              : SUM_BITS'(rdata_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.capture) begin
         acc_in = '0;
      end else if (rvalid_ff) begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign numer   = {acc_ff, FRAC_BITS'(0)} + NUM_BITS'(ROUND_BIAS);
   assign prod_in = PROD_BITS'(numer) * PROD_BITS'(RECIP_VALUE);

   always_ff @(posedge clock) begin
      if (cmd.divide) begin
         prod_ff <= prod_in;
      end
   end

   assign quot   = prod_ff[PROD_BITS-1:RECIP_SHIFT];
   assign result = (quot > QUO_BITS'(OUT_MAX)) ? OUT_BITS'(OUT_MAX) : OUT_BITS'(quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_filtered_value = out_ff;

   assign status.req_is_read = (rcgs_op_type'(req_opcode) == OP_READ);
   assign status.out_free    = !out_valid_ff || !rsp_stall;

endmodule

/* hw/rtl/rgb_current_grid_smoother.sv */
// A write beat stores one current sample in a 10x10x10 cube addressed by red,
// green and blue level. A read beat returns the smoothed value of a cell, the
// sum of the three axis terms divided by nine and rounded to 4 fraction bits;
// it runs seven reads in turn from the single-port cell memory, a drain step
// to finish accumulating, the reciprocal multiply and the load of the result
// register, which is held off while an earlier result is stalled. The result
// register lets the next beat be taken while a result still waits. Levels past
// the grid clamp to the last level. The memory is not cleared; read a cell
// only after it and its neighbors have been written.
module rgb_current_grid_smoother
   import rcgs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  level_type  req_red_level,
   input  level_type  req_green_level,
   input  level_type  req_blue_level,
   input  sample_type req_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output out_type    rsp_filtered_value
);

   rcgs_cmd_type    cmd;
   rcgs_status_type status;

   rcgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rcgs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_red_level      (req_red_level),
      .req_green_level    (req_green_level),
      .req_blue_level     (req_blue_level),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

/* hw/rtl/rcgs_checker.sv */
// Port-level checks for the grid smoother, bound to the top level.
// Depends on rcgs_pkg and the assertion macros header.
`include "rgb_current_grid_smoother_assert.svh"

module rcgs_checker
   import rcgs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_opcode,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input out_type    rsp_filtered_value
);

   // A read beat keeps the input side busy through its fetch and divide.
   `RCGS_ASSERT_NOW(a_read_busy, req_valid && !req_stall && req_opcode, ##9 req_stall, "read beat released the input too early")

   // A write beat blocks for exactly one cycle.
   `RCGS_ASSERT_NEXT(a_write_short, req_valid && !req_stall && !req_opcode, req_stall ##1 !req_stall, "write beat did not take two cycles")

   `RCGS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   `RCGS_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_filtered_value), "stalled result changed")

endmodule

bind rgb_current_grid_smoother rcgs_checker u_checker (.*);
